// File: hdl/bba_pkg.sv
// Shared constants, command/status types and tree index helpers for the buddy allocator.
package bba_pkg;

    localparam int LEVELS = 6;
    localparam int LVL_W  = 3;
    localparam int OFF_W  = LEVELS - 1;
    localparam int NODES  = (1 << LEVELS) - 1;
    localparam int NODE_W = $clog2(NODES);
    localparam int CNT_W  = $clog2((1 << (LEVELS - 1)) + 1);
    localparam int SLOT_W = (OFF_W > 0) ? OFF_W : 1;
    localparam int HALF_W = OFF_W + 1;

    typedef enum logic [1:0] {
        RES_GRANTED  = 2'd0,
        RES_NO_SPACE = 2'd1,
        RES_RETURNED = 2'd2
    } bba_res_t;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_LOAD,
        OP_SEEK,
        OP_POP_RD,
        OP_POP_WR,
        OP_PUSH_L,
        OP_PUSH_R,
        OP_RM_RD,
        OP_RM_WR,
        OP_PUSH_SELF
    } bba_op_t;

    typedef struct packed {
        bba_op_t op;
    } bba_cmd_t;

    typedef struct packed {
        logic             tgt_bad;
        logic             found;
        logic             at_tgt;
        logic             cur_empty;
        logic             self_listed;
        logic             lvl_zero;
        logic             buddy_listed;
        logic [OFF_W-1:0] pop_off;
    } bba_stat_t;

    function automatic logic [NODE_W-1:0] level_base(input logic [LVL_W-1:0] l);
        return NODE_W'((32'd1 << l) - 32'd1);
    endfunction

    function automatic logic [NODE_W-1:0] node_id(input logic [LVL_W-1:0] l,
                                                  input logic [OFF_W-1:0] off);
        logic [OFF_W-1:0] idx;
        idx = off >> (OFF_W - int'(l));
        return NODE_W'(level_base(l) + NODE_W'(idx));
    endfunction

    function automatic logic [OFF_W-1:0] align(input logic [OFF_W-1:0] off,
                                               input logic [LVL_W-1:0] l);
        int sh;
        sh = OFF_W - int'(l);
        if (sh < 0) begin
            return off;
        end
        return (off >> sh) << sh;
    endfunction

    function automatic logic [HALF_W-1:0] half(input logic [LVL_W-1:0] l);
        int sh;
        sh = OFF_W - int'(l);
        if (sh < 0) begin
            return '0;
        end
        return HALF_W'(32'd1 << sh);
    endfunction

endpackage

// File: hdl/buddy_block_allocator.sv
// Top level of the buddy block allocator: stream ports, controller and datapath.
//
//  channel | dir | tdata                        | tuser
//  s_      | in  | [2:0] level, [7:3] offset    | [0] kind (0 allocate, 1 return)
//  m_      | out | [4:0] granted_offset, zeros  | [1:0] status
//
// One request at a time; s_tready is high only while the sequencer is idle.
// An allocate seeks the deepest non-empty level at or above its target, then
// splits one level at a time through the per-level free lists until it can pop
// a block at the target; it is refused if the level is out of range or no such
// level is free. A return merges with its buddy level by level while it is listed.
// The free-list memories need no clearing pass: reset initialises only the level
// counts and the listed bits. A stalled result holds in the output register
// and the next request is taken once it has been loaded there.
module buddy_block_allocator (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [2:0] level, [7:3] block_offset
    input  logic       s_tuser,   // [0] kind
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [4:0] granted_offset, [7:5] zero
    output logic [1:0] m_tuser    // [1:0] status
);

    bba_pkg::bba_cmd_t         cmd;
    bba_pkg::bba_stat_t        stat;
    bba_pkg::bba_res_t         out_status;
    logic [bba_pkg::OFF_W-1:0] out_offset;

    // sequence the split and merge walks
    bba_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_kind    (s_tuser),
        .in_ready   (s_tready),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_status (out_status),
        .out_offset (out_offset),
        .cmd        (cmd),
        .stat       (stat)
    );

    // hold the free lists and the tree state
    bba_dpath u_dpath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .in_level  (s_tdata[2:0]),
        .in_offset (s_tdata[7:3]),
        .stat      (stat)
    );

    assign m_tdata = {3'b000, out_offset};
    assign m_tuser = out_status;

endmodule

// File: hdl/bba_dpath.sv
// Datapath: free lists, node map, listed bits, level counts and the walk registers.
module bba_dpath (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  bba_pkg::bba_cmd_t         cmd,
    input  logic [bba_pkg::LVL_W-1:0] in_level,
    input  logic [bba_pkg::OFF_W-1:0] in_offset,
    output bba_pkg::bba_stat_t        stat
);

    logic [bba_pkg::LVL_W-1:0]  lvl_reg, lvl_next;
    logic [bba_pkg::LVL_W-1:0]  tgt_reg, tgt_next;
    logic [bba_pkg::OFF_W-1:0]  off_reg, off_next;
    logic [bba_pkg::OFF_W-1:0]  p_reg, p_next;
    logic [bba_pkg::CNT_W-1:0]  cnt_reg [bba_pkg::LEVELS];
    logic [bba_pkg::CNT_W-1:0]  cnt_next [bba_pkg::LEVELS];
    logic [bba_pkg::NODES-1:0]  listed_reg, listed_next;

    logic [bba_pkg::OFF_W-1:0]  fs_mem  [bba_pkg::NODES];
    logic [bba_pkg::SLOT_W-1:0] son_mem [bba_pkg::NODES];
    logic [bba_pkg::OFF_W-1:0]  fs_q;
    logic [bba_pkg::SLOT_W-1:0] son_q;

    logic [bba_pkg::CNT_W-1:0]  cur_cnt, tgt_cnt, push_cnt;
    logic [bba_pkg::NODE_W-1:0] cur_base, last_idx, self_id, buddy_id;
    logic [bba_pkg::LVL_W-1:0]  push_lvl, seek_lvl;
    logic [bba_pkg::OFF_W-1:0]  push_off, pop_off, last_off;
    logic [bba_pkg::NODE_W-1:0] push_id, pop_id, last_id;
    logic                       push_ok, found;
    logic [bba_pkg::CNT_W-1:0]  last_cnt;
    logic [bba_pkg::CNT_W-1:0]  slot;

    function automatic logic is_listed(input logic [bba_pkg::NODES-1:0] v,
                                       input logic [bba_pkg::NODE_W-1:0] id);
        return (int'(id) < bba_pkg::NODES) ? v[id] : 1'b0;
    endfunction

    always_comb begin
        cur_cnt  = '0;
        tgt_cnt  = '0;
        push_cnt = '0;
        seek_lvl = '0;
        found    = 1'b0;
        push_lvl = lvl_reg;
        push_off = off_reg;
        case (cmd.op)
            bba_pkg::OP_PUSH_L: begin
                push_lvl = bba_pkg::LVL_W'(lvl_reg + 1'b1);
                push_off = p_reg;
            end
            bba_pkg::OP_PUSH_R: begin
                push_lvl = bba_pkg::LVL_W'(lvl_reg + 1'b1);
                push_off = bba_pkg::OFF_W'(p_reg + bba_pkg::half(push_lvl));
            end
            default: begin
                push_lvl = lvl_reg;
                push_off = off_reg;
            end
        endcase
        for (int i = 0; i < bba_pkg::LEVELS; i++) begin
            if (int'(lvl_reg) == i) begin
                cur_cnt = cnt_reg[i];
            end
            if (int'(tgt_reg) == i) begin
                tgt_cnt = cnt_reg[i];
            end
            if (int'(push_lvl) == i) begin
                push_cnt = cnt_reg[i];
            end
            // deepest non-empty level at or above the target wins
            if (i <= int'(tgt_reg) && cnt_reg[i] != '0) begin
                seek_lvl = bba_pkg::LVL_W'(i);
                found    = 1'b1;
            end
        end
    end

    assign cur_base = bba_pkg::level_base(lvl_reg);
    assign last_cnt = bba_pkg::CNT_W'(cur_cnt - 1'b1);
    assign last_idx = bba_pkg::NODE_W'(cur_base + bba_pkg::NODE_W'(last_cnt));
    assign self_id  = bba_pkg::node_id(lvl_reg, off_reg);
    assign buddy_id = bba_pkg::node_id(lvl_reg,
                          off_reg ^ bba_pkg::OFF_W'(bba_pkg::half(lvl_reg)));

    assign push_id  = bba_pkg::node_id(push_lvl, push_off);
    assign push_ok  = !is_listed(listed_reg, push_id)
                      && (int'(push_cnt) < (1 << int'(push_lvl)));

    assign pop_off  = bba_pkg::align(fs_q, lvl_reg);
    assign pop_id   = bba_pkg::node_id(lvl_reg, pop_off);
    assign last_off = pop_off;
    assign last_id  = pop_id;
    assign slot     = (bba_pkg::CNT_W'(son_q) < last_cnt) ? bba_pkg::CNT_W'(son_q) : last_cnt;

    always_comb begin
        lvl_next    = lvl_reg;
        tgt_next    = tgt_reg;
        off_next    = off_reg;
        p_next      = p_reg;
        cnt_next    = cnt_reg;
        listed_next = listed_reg;
        case (cmd.op)
            bba_pkg::OP_LOAD: begin
                lvl_next = in_level;
                tgt_next = in_level;
                off_next = bba_pkg::align(in_offset, in_level);
            end
            bba_pkg::OP_SEEK: begin
                lvl_next = seek_lvl;
            end
            bba_pkg::OP_POP_WR: begin
                p_next              = pop_off;
                listed_next[pop_id] = 1'b0;
                for (int i = 0; i < bba_pkg::LEVELS; i++) begin
                    if (int'(lvl_reg) == i) begin
                        cnt_next[i] = last_cnt;
                    end
                end
            end
            bba_pkg::OP_PUSH_L, bba_pkg::OP_PUSH_R, bba_pkg::OP_PUSH_SELF: begin
                if (push_ok) begin
                    listed_next[push_id] = 1'b1;
                    for (int i = 0; i < bba_pkg::LEVELS; i++) begin
                        if (int'(push_lvl) == i) begin
                            cnt_next[i] = bba_pkg::CNT_W'(push_cnt + 1'b1);
                        end
                    end
                end
                if (cmd.op == bba_pkg::OP_PUSH_R) begin
                    lvl_next = push_lvl;
                end
            end
            bba_pkg::OP_RM_WR: begin
                listed_next[buddy_id] = 1'b0;
                for (int i = 0; i < bba_pkg::LEVELS; i++) begin
                    if (int'(lvl_reg) == i) begin
                        cnt_next[i] = last_cnt;
                    end
                end
                // climb to the parent and realign
                lvl_next = bba_pkg::LVL_W'(lvl_reg - 1'b1);
                off_next = bba_pkg::align(off_reg, lvl_next);
            end
            default: begin
                lvl_next = lvl_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            listed_reg <= bba_pkg::NODES'(1);
            for (int i = 0; i < bba_pkg::LEVELS; i++) begin
                cnt_reg[i] <= (i == 0) ? bba_pkg::CNT_W'(1) : '0;
            end
        end else begin
            listed_reg <= listed_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        lvl_reg <= lvl_next;
        tgt_reg <= tgt_next;
        off_reg <= off_next;
        p_reg   <= p_next;
    end

    // free-list and node-map memories: one write, one registered read each
    always_ff @(posedge aclk) begin
        if ((cmd.op == bba_pkg::OP_PUSH_L || cmd.op == bba_pkg::OP_PUSH_R
             || cmd.op == bba_pkg::OP_PUSH_SELF) && push_ok) begin
            fs_mem[bba_pkg::NODE_W'(bba_pkg::level_base(push_lvl)
                   + bba_pkg::NODE_W'(push_cnt))] <= push_off;
            son_mem[push_id] <= bba_pkg::SLOT_W'(push_cnt);
        end else if (cmd.op == bba_pkg::OP_RM_WR) begin
            fs_mem[bba_pkg::NODE_W'(cur_base + bba_pkg::NODE_W'(slot))] <= last_off;
            son_mem[last_id] <= bba_pkg::SLOT_W'(slot);
        end
        if (cmd.op == bba_pkg::OP_POP_RD || cmd.op == bba_pkg::OP_RM_RD) begin
            fs_q <= fs_mem[last_idx];
        end
        if (cmd.op == bba_pkg::OP_RM_RD) begin
            son_q <= son_mem[buddy_id];
        end
    end

    assign stat.tgt_bad      = int'(tgt_reg) >= bba_pkg::LEVELS;
    assign stat.found        = found;
    assign stat.at_tgt       = lvl_reg == tgt_reg;
    assign stat.cur_empty    = (cur_cnt == '0) || (tgt_cnt == '0 && lvl_reg == tgt_reg);
    assign stat.self_listed  = is_listed(listed_reg, self_id);
    assign stat.lvl_zero     = lvl_reg == '0;
    assign stat.buddy_listed = is_listed(listed_reg, buddy_id);
    assign stat.pop_off      = p_reg;

endmodule

// File: hdl/bba_ctrl.sv
// Controller: sequences allocate splits and return merges, and holds the result register.
module bba_ctrl (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      in_valid,
    input  logic                      in_kind,
    output logic                      in_ready,
    output logic                      out_valid,
    input  logic                      out_ready,
    output bba_pkg::bba_res_t         out_status,
    output logic [bba_pkg::OFF_W-1:0] out_offset,
    output bba_pkg::bba_cmd_t         cmd,
    input  bba_pkg::bba_stat_t        stat
);

    typedef enum logic [12:0] {
        ST_IDLE   = 13'b0000000000001,
        ST_A_SEEK = 13'b0000000000010,
        ST_A_LOOP = 13'b0000000000100,
        ST_A_PRD  = 13'b0000000001000,
        ST_A_PWR  = 13'b0000000010000,
        ST_A_PSHL = 13'b0000000100000,
        ST_A_PSHR = 13'b0000001000000,
        ST_A_FRD  = 13'b0000010000000,
        ST_A_FWR  = 13'b0000100000000,
        ST_R_LOOP = 13'b0001000000000,
        ST_R_RD   = 13'b0010000000000,
        ST_R_WR   = 13'b0100000000000,
        ST_FINISH = 13'b1000000000000
    } state_t;

    state_t                    state_reg, state_next;
    bba_pkg::bba_res_t         res_reg, res_next;
    logic                      m_valid_reg, m_valid_next;
    bba_pkg::bba_res_t         m_status_reg, m_status_next;
    logic [bba_pkg::OFF_W-1:0] m_offset_reg, m_offset_next;

    assign in_ready = state_reg == ST_IDLE;

    always_comb begin
        state_next    = state_reg;
        res_next      = res_reg;
        m_valid_next  = m_valid_reg && !out_ready;
        m_status_next = m_status_reg;
        m_offset_next = m_offset_reg;
        cmd.op        = bba_pkg::OP_NOP;
        case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    cmd.op     = bba_pkg::OP_LOAD;
                    state_next = in_kind ? ST_R_LOOP : ST_A_SEEK;
                end
            end
            ST_A_SEEK: begin
                if (stat.tgt_bad || !stat.found) begin
                    res_next   = bba_pkg::RES_NO_SPACE;
                    state_next = ST_FINISH;
                end else begin
                    cmd.op     = bba_pkg::OP_SEEK;
                    state_next = ST_A_LOOP;
                end
            end
            ST_A_LOOP: begin
                if (!stat.at_tgt) begin
                    state_next = ST_A_PRD;
                end else if (stat.cur_empty) begin
                    res_next   = bba_pkg::RES_NO_SPACE;
                    state_next = ST_FINISH;
                end else begin
                    state_next = ST_A_FRD;
                end
            end
            ST_A_PRD: begin
                cmd.op     = bba_pkg::OP_POP_RD;
                state_next = ST_A_PWR;
            end
            ST_A_PWR: begin
                cmd.op     = bba_pkg::OP_POP_WR;
                state_next = ST_A_PSHL;
            end
            ST_A_PSHL: begin
                cmd.op     = bba_pkg::OP_PUSH_L;
                state_next = ST_A_PSHR;
            end
            ST_A_PSHR: begin
                cmd.op     = bba_pkg::OP_PUSH_R;
                state_next = ST_A_LOOP;
            end
            ST_A_FRD: begin
                cmd.op     = bba_pkg::OP_POP_RD;
                state_next = ST_A_FWR;
            end
            ST_A_FWR: begin
                cmd.op     = bba_pkg::OP_POP_WR;
                res_next   = bba_pkg::RES_GRANTED;
                state_next = ST_FINISH;
            end
            ST_R_LOOP: begin
                res_next = bba_pkg::RES_RETURNED;
                if (stat.tgt_bad || stat.self_listed) begin
                    state_next = ST_FINISH;
                end else if (!stat.lvl_zero && stat.buddy_listed) begin
                    state_next = ST_R_RD;
                end else begin
                    cmd.op     = bba_pkg::OP_PUSH_SELF;
                    state_next = ST_FINISH;
                end
            end
            ST_R_RD: begin
                cmd.op     = bba_pkg::OP_RM_RD;
                state_next = ST_R_WR;
            end
            ST_R_WR: begin
                cmd.op     = bba_pkg::OP_RM_WR;
                state_next = ST_R_LOOP;
            end
            ST_FINISH: begin
                // hold until the result register is free
                if (!m_valid_reg || out_ready) begin
                    m_valid_next  = 1'b1;
                    m_status_next = res_reg;
                    m_offset_next = (res_reg == bba_pkg::RES_GRANTED) ? stat.pop_off : '0;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        res_reg      <= res_next;
        m_status_reg <= m_status_next;
        m_offset_reg <= m_offset_next;
    end

    assign out_valid  = m_valid_reg;
    assign out_status = m_status_reg;
    assign out_offset = m_offset_reg;

endmodule

// File: dv/tb_buddy_block_allocator.sv
// Self-checking testbench for the buddy block allocator: directed and random requests.
`timescale 1ns / 1ps

module tb_buddy_block_allocator;

    localparam bit KIND_ALLOC  = 1'b0;
    localparam bit KIND_RETURN = 1'b1;
    localparam int SMALLEST    = bba_pkg::LEVELS - 1;   // deepest legal level
    localparam int POOL        = 1 << (bba_pkg::LEVELS - 1);

    logic       aclk;
    logic       aresetn;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;    // [2:0] level, [7:3] block_offset
    logic       s_tuser;    // [0] kind
    logic       m_tvalid;
    logic       m_tready;
    logic [7:0] m_tdata;    // [4:0] granted_offset, [7:5] zero
    logic [1:0] m_tuser;    // [1:0] status

    buddy_block_allocator i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    // 10 ns clock
    initial aclk = 1'b0;
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    typedef struct packed {
        bba_pkg::bba_res_t status;
        logic [4:0]        offset;
    } grant_t;

    typedef struct packed {
        logic [2:0] level;
        logic [4:0] offset;
    } block_t;

    // Shadow copy of the allocator state
    logic [4:0] list_off   [bba_pkg::NODES];
    logic [5:0] list_count [bba_pkg::LEVELS];
    logic [5:0] node_slot  [bba_pkg::NODES];
    logic       node_free  [bba_pkg::NODES];

    grant_t expected_grants[$];
    block_t held_blocks[$];     // blocks granted and not yet handed back
    int     fail_count;
    int     hold_requests;      // bumped by a test to ask for a long receiver hold

    function automatic int tree_node(int l, int off);
        return ((1 << l) - 1) + ((off & (POOL - 1)) >> (SMALLEST - l));
    endfunction

    function automatic void list_push(int l, int off);
        int id;
        int slot;
        id   = tree_node(l, off);
        slot = list_count[l];
        if (node_free[id] || slot >= (1 << l)) return;
        list_off[(1 << l) - 1 + slot] = 5'(off & (POOL - 1));
        node_slot[id]  = 6'(slot);
        node_free[id]  = 1'b1;
        list_count[l]  = 6'(slot + 1);
    endfunction

    // Unlink a node by moving the list's last entry into its slot
    function automatic void list_unlink(int l, int id);
        int slot;
        int last;
        int last_off;
        if (!node_free[id] || list_count[l] == 0) return;
        slot = node_slot[id];
        last = list_count[l] - 1;
        if (slot > last) slot = last;
        last_off = list_off[(1 << l) - 1 + last];
        list_off[(1 << l) - 1 + slot] = 5'(last_off);
        node_slot[tree_node(l, last_off)] = 6'(slot);
        node_free[id]  = 1'b0;
        node_slot[id]  = '0;
        list_count[l]  = 6'(last);
    endfunction

    function automatic int list_pop(int l);
        int off;
        off = list_off[(1 << l) - 1 + list_count[l] - 1];
        list_unlink(l, tree_node(l, off));
        return off;
    endfunction

    function automatic void clear_shadow();
        for (int i = 0; i < bba_pkg::NODES; i++) begin
            list_off[i]  = '0;
            node_slot[i] = '0;
            node_free[i] = 1'b0;
        end
        for (int i = 0; i < bba_pkg::LEVELS; i++) list_count[i] = '0;
        list_count[0] = 6'd1;
        node_free[0]  = 1'b1;
    endfunction

    // Work out the response to one request and update the shadow state
    function automatic grant_t allocator_response(bit kind, int lvl, int off);
        grant_t g;
        int     s;
        int     p;
        int     bsz;
        g.status = bba_pkg::RES_RETURNED;
        g.offset = '0;
        if (kind == KIND_ALLOC) begin
            g.status = bba_pkg::RES_NO_SPACE;
            if (lvl >= bba_pkg::LEVELS) return g;
            for (s = lvl; s >= 0; s--)
                if (list_count[s] != 0) break;
            if (s < 0) return g;
            for (int i = s; i < lvl; i++) begin
                p = list_pop(i);
                list_push(i + 1, p);
                list_push(i + 1, (p + (1 << (SMALLEST - i - 1))) & (POOL - 1));
            end
            if (list_count[lvl] == 0) return g;
            g.status = bba_pkg::RES_GRANTED;
            g.offset = 5'(list_pop(lvl));
            return g;
        end
        if (lvl >= bba_pkg::LEVELS) return g;
        bsz = 1 << (SMALLEST - lvl);
        off = off & (POOL - 1) & ~(bsz - 1);
        // merge walk: climb while the buddy is free
        forever begin
            if (node_free[tree_node(lvl, off)]) break;
            if (lvl == 0) begin
                list_push(0, off);
                break;
            end
            bsz = 1 << (SMALLEST - lvl);
            if (node_free[tree_node(lvl, off ^ bsz)]) begin
                list_unlink(lvl, tree_node(lvl, off ^ bsz));
                lvl--;
                off = off & ~((1 << (SMALLEST - lvl)) - 1);
            end else begin
                list_push(lvl, off);
                break;
            end
        end
        return g;
    endfunction

    // Offer one request, hold it until taken, then predict its response
    task automatic send_request(bit kind, int lvl, int off);
        grant_t g;
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {5'(off), 3'(lvl)};
        do @(posedge aclk); while (!s_tready);
        g = allocator_response(kind, lvl, off);
        expected_grants.insert(expected_grants.size(), g);
        if (g.status == bba_pkg::RES_GRANTED) begin
            held_blocks.insert(held_blocks.size(), {3'(lvl), g.offset});
        end
    endtask

    task automatic idle_sender(int cycles);
        repeat (cycles) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
        end
    endtask

    task automatic wait_drained();
        idle_sender(1);
        while (expected_grants.size() != 0) @(negedge aclk);
    endtask

    // Mostly well-formed traffic: allocate, hand back held blocks; some noise
    task automatic random_request();
        int pick;
        int idx;
        block_t b;
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
            send_request(KIND_ALLOC,
                         (pick < 3) ? $urandom_range(6, 7) : $urandom_range(0, 5),
                         $urandom_range(0, 31));
        end else if (pick < 90 && held_blocks.size() != 0) begin
            idx = $urandom_range(0, held_blocks.size() - 1);
            b   = held_blocks[idx];
            held_blocks.delete(idx);
            send_request(KIND_RETURN, b.level, b.offset);
        end else begin
            // stray return: any level, any offset
            send_request(KIND_RETURN, $urandom_range(0, 7), $urandom_range(0, 31));
        end
    endtask

    task automatic random_traffic(int count);
        int burst;
        burst = 0;
        for (int n = 0; n < count; n++) begin
            if (burst == 0) begin
                burst = $urandom_range(1, 24);
                if ($urandom_range(0, 3) != 0) idle_sender($urandom_range(1, 8));
            end
            burst--;
            random_request();
        end
    endtask

    task automatic test_directed_corners();
        send_request(KIND_ALLOC, 0, 0);          // whole pool
        send_request(KIND_ALLOC, 0, 0);          // empty pool
        send_request(KIND_ALLOC, SMALLEST, 31);  // empty pool at deepest level
        send_request(KIND_RETURN, 0, 31);        // offset masked down to 0
        send_request(KIND_RETURN, 0, 0);         // already free
        send_request(KIND_ALLOC, SMALLEST, 0);   // full split from the root
        send_request(KIND_ALLOC, SMALLEST, 0);
        send_request(KIND_ALLOC, 3, 0);
        send_request(KIND_ALLOC, 6, 0);          // level out of range
        send_request(KIND_ALLOC, 7, 31);
        send_request(KIND_RETURN, 7, 31);        // ignored return
        send_request(KIND_RETURN, 6, 5);
        send_request(KIND_RETURN, SMALLEST, 1);  // buddy not listed, so listed without a merge
        send_request(KIND_RETURN, 2, 13);        // unaligned offset
        send_request(KIND_RETURN, 4, 2);         // inside a larger free block
        send_request(KIND_ALLOC, 1, 0);
        send_request(KIND_ALLOC, 1, 0);
        send_request(KIND_ALLOC, 1, 0);
        send_request(KIND_RETURN, 1, 16);
        send_request(KIND_RETURN, 1, 0);         // merge back to the root
        send_request(KIND_RETURN, 1, 0);
        held_blocks.delete();
        wait_drained();
    endtask

    // Receiver holds off while requests keep coming, so the block stalls its input
    task automatic test_output_backpressure();
        hold_requests++;
        for (int n = 0; n < 12; n++) random_request();
        wait_drained();
    endtask

    task automatic test_random_traffic();
        random_traffic(360);
        wait_drained();     // full pause before resuming
        random_traffic(360);
    endtask

    // Receiver stall pattern: phases of always ready, random, and mostly stalled
    int seen_holds;
    int hold_left;
    int phase_left;
    int phase_mode;
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (hold_requests != seen_holds) begin
                seen_holds = hold_requests;
                hold_left  = 300;
            end
            if (phase_left == 0) begin
                phase_left = $urandom_range(10, 80);
                phase_mode = $urandom_range(0, 2);
            end
            phase_left--;
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                case (phase_mode)
                    0: m_tready <= 1'b1;
                    1: m_tready <= 1'($urandom_range(0, 1));
                    default: m_tready <= ($urandom_range(0, 4) == 0);
                endcase
            end
        end
    end

    // Compare each delivered response with the oldest prediction
    always @(posedge aclk) begin
        grant_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_grants.size() == 0) begin
                $display("%0t: unexpected response status=%0d offset=%0d",
                         $time, m_tuser, m_tdata);
                fail_count++;
            end else begin
                want = expected_grants.pop_front();
                if (m_tuser !== want.status) begin
                    $display("%0t: status expected %0d actual %0d", $time, want.status, m_tuser);
                    fail_count++;
                end
                if (m_tdata !== {3'b000, want.offset}) begin
                    $display("%0t: tdata expected %0d actual %0d",
                             $time, {3'b000, want.offset}, m_tdata);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tuser       = 1'b0;
        m_tready      = 1'b0;
        aresetn       = 1'b0;
        fail_count    = 0;
        hold_requests = 0;
        seen_holds    = 0;
        hold_left     = 0;
        phase_left    = 0;
        phase_mode    = 0;
        clear_shadow();
        repeat (6) @(negedge aclk);
        aresetn = 1'b1;

        test_directed_corners();
        test_output_backpressure();
        test_random_traffic();

        wait_drained();
        repeat (40) @(negedge aclk);
        if (fail_count == 0 && expected_grants.size() == 0) begin
            $display("tb_buddy_block_allocator: PASS");
        end else begin
            $display("tb_buddy_block_allocator: FAIL");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #3_000_000;
        $display("tb_buddy_block_allocator: FAIL");
        $finish;
    end

endmodule

// File: filelist.f
hdl/bba_pkg.sv
hdl/bba_dpath.sv
hdl/bba_ctrl.sv
hdl/buddy_block_allocator.sv
dv/tb_buddy_block_allocator.sv
